// ----- src/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// Holds the request and response word layouts and the scan result flags.
// No dependencies; lkv_scan, the top level and the bench refer to it by scoped names.
package lkv_pkg;

  localparam int CFG_W           = 5;
  localparam int KEY_W           = 32;
  localparam int DATA_W          = 32;
  localparam int WIDE_W          = 64;
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       write_value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic [DATA_W-1:0]       read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
    logic [DATA_W-1:0]       evicted_value;
  } rsp_t;

  // Summary of one pass over the entry table.
  typedef struct packed {
    logic found;
    logic free_found;
    logic lru_found;
  } scan_flags_t;

endpackage

// ----- src/lkv_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the key, value and recency stores of the cache.
// Depends on nothing.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lkv_scan.sv -----
// Compare unit of the cache: while en is high, looks at one entry per cycle
// and keeps the key match, the lowest free slot and the least recent valid entry.
// Depends on lkv_pkg.
module lkv_scan #(
  parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic                              en,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    idx,
  input  logic                              entry_valid,
  input  logic [lkv_pkg::KEY_W-1:0]         key_rd,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    rank_rd,
  input  logic [lkv_pkg::KEY_W-1:0]         key,
  output lkv_pkg::scan_flags_t              flags,
  output logic [$clog2(MAX_ENTRIES)-1:0]    match_idx,
  output logic [$clog2(MAX_ENTRIES)-1:0]    match_rank,
  output logic [$clog2(MAX_ENTRIES)-1:0]    free_idx,
  output logic [$clog2(MAX_ENTRIES)-1:0]    lru_idx,
  output logic [lkv_pkg::KEY_W-1:0]         lru_key
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  logic [IDX_W-1:0] lru_rank;
  logic             is_match;
  logic             take_free;
  logic             take_lru;

  assign is_match  = en && entry_valid && (key_rd == key);
  assign take_free = en && !entry_valid && !flags.free_found;
  // The first valid entry seeds the search; later ones win only when strictly older.
  assign take_lru  = en && entry_valid && (!flags.lru_found || (rank_rd > lru_rank));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      flags <= '0;
    end else begin
      if (is_match) begin
        flags.found <= 1'b1;
      end
      if (take_free) begin
        flags.free_found <= 1'b1;
      end
      if (take_lru) begin
        flags.lru_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_match) begin
      match_idx  <= idx;
      match_rank <= rank_rd;
    end
    if (take_free) begin
      free_idx <= idx;
    end
    if (take_lru) begin
      lru_idx  <= idx;
      lru_rank <= rank_rd;
      lru_key  <= key_rd;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    flags.found |=> flags.found || $past(clear))
    else $error("match flag dropped during a scan");

  assert property (@(posedge clk) disable iff (rst)
    (en && entry_valid && !clear) |=> flags.lru_found)
    else $error("valid entry seen but no least recent candidate kept");

  assert property (@(posedge clk) disable iff (rst)
    (flags.found && en && !clear) |-> !(entry_valid && key_rd == key && idx != match_idx))
    else $error("key present in two valid entries");

endmodule

// ----- src/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: sequencer, capacity register,
// entry valid bits and count, and the key, value and recency RAMs.
// Depends on lkv_pkg, lkv_ram and lkv_scan.
//
// Usage:
//   The request channel (req_valid, req_stall, req) carries one word per get
//   or put. The response channel (rsp_valid, rsp_stall, rsp) returns exactly
//   one word per request, in order. A word moves at a clock edge with valid
//   high and stall low. The capacity register is written through cfg_valid,
//   cfg_ready and cfg_data; the user must write it only while no request is
//   in flight, as the block itself does not enforce this.
//   One request is handled at a time. A scan pass reads one entry per cycle
//   from the key and recency RAMs, a resolve state decides the outcome, an
//   aging pass rewrites the recency RAM one entry per cycle, and a finish
//   state commits the entry. A hit or a put runs all four before the
//   response register is loaded; a get miss goes from resolve to the
//   response. The single read and write port of the recency RAM sets this
//   sequence. req_stall is high from acceptance until the response word is
//   taken, so a new request is taken in the cycle after the response at the
//   earliest. If the receiver stalls, the response word holds steady and no
//   new request is taken. Reset empties the cache (valid bits and count
//   cleared) and loads capacity with 16; it needs no clearing pass.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::DEF_MAX_ENTRIES,
  parameter int VALUE_WIDTH = lkv_pkg::DEF_VALUE_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  lkv_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lkv_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkv_pkg::CFG_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int PTR_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = ((PTR_W > lkv_pkg::CFG_W) ? PTR_W : lkv_pkg::CFG_W) + 1;
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(MAX_ENTRIES);
  localparam logic [CMP_W-1:0] CMP_MAX = CMP_W'(MAX_ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_RESOLVE = 6'b000100,
    S_AGE     = 6'b001000,
    S_FINISH  = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

  state_t                    state;
  logic [lkv_pkg::CFG_W-1:0] capacity;
  logic [PTR_W-1:0]          ptr;
  logic                      cmp_vld;
  logic [IDX_W-1:0]          cmp_idx;
  logic [MAX_ENTRIES-1:0]    valid;
  logic [PTR_W-1:0]          count;
  lkv_pkg::req_t             req_q;

  // Outcome of the scan, held through the aging pass and the commit.
  logic             op_hit;
  logic             op_ins;
  logic             op_evict;
  logic [IDX_W-1:0] op_tgt;
  logic [IDX_W-1:0] op_thr;

  lkv_pkg::scan_flags_t   flags;
  logic [IDX_W-1:0]       match_idx;
  logic [IDX_W-1:0]       match_rank;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       lru_idx;
  logic [lkv_pkg::KEY_W-1:0] lru_key;

  logic [lkv_pkg::KEY_W-1:0] key_rdata;
  logic [VALUE_WIDTH-1:0]    val_rdata;
  logic [IDX_W-1:0]          rank_rdata;

  logic                   rank_we;
  logic [IDX_W-1:0]       rank_waddr;
  logic [IDX_W-1:0]       rank_wdata;
  logic [IDX_W-1:0]       rd_addr;
  logic                   tbl_we;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [VALUE_WIDTH-1:0] val_raddr_unused;
  logic [IDX_W-1:0]       val_raddr;

  logic [CMP_W-1:0]       cap_w;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic                   res_evict;
  logic                   res_ins;
  logic [IDX_W-1:0]       res_tgt;
  logic                   age_hit;

  logic [lkv_pkg::WIDE_W-1:0] wr_wide;
  logic [lkv_pkg::WIDE_W-1:0] rd_wide;
  logic [lkv_pkg::DATA_W-1:0] rd_value;

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;

  // Effective capacity: zero acts as one, anything above the table size saturates.
  always_comb begin
    cap_w = CMP_W'(capacity);
    if (cap_w == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_w > CMP_MAX) begin
      eff_cap = CMP_MAX;
    end else begin
      eff_cap = cap_w;
    end
  end

  assign full      = (CMP_W'(count) >= eff_cap);
  assign res_evict = !flags.found && (req_q.mode == lkv_pkg::MODE_PUT) && full
                     && flags.lru_found;
  assign res_ins   = !flags.found && (req_q.mode == lkv_pkg::MODE_PUT)
                     && (res_evict || flags.free_found);
  assign res_tgt   = flags.found ? match_idx : (res_evict ? lru_idx : free_idx);

  // An inserted entry ages every other valid entry; a hit ages only the younger ones.
  assign age_hit = cmp_vld && valid[cmp_idx] && (cmp_idx != op_tgt)
                   && (op_ins || (rank_rdata < op_thr));

  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = cmp_idx;
    rank_wdata = rank_rdata + IDX_W'(1);
    if (state == S_AGE) begin
      rank_we = age_hit;
    end else if (state == S_FINISH) begin
      rank_we    = 1'b1;
      rank_waddr = op_tgt;
      rank_wdata = '0;
    end
  end

  assign rd_addr   = (ptr < PTR_END) ? ptr[IDX_W-1:0] : '0;
  assign tbl_we    = (state == S_FINISH) && (req_q.mode == lkv_pkg::MODE_PUT);
  assign wr_wide   = lkv_pkg::WIDE_W'(req_q.write_value);
  assign val_wdata = wr_wide[VALUE_WIDTH-1:0];
  assign rd_wide   = lkv_pkg::WIDE_W'(val_rdata);
  assign rd_value  = rd_wide[lkv_pkg::DATA_W-1:0];
  assign val_raddr = op_hit ? op_tgt : lru_idx;
  assign val_raddr_unused = '0;

  lkv_ram #(.WIDTH(lkv_pkg::KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (op_tgt),
    .wdata (req_q.key),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  lkv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (op_tgt),
    .wdata (val_wdata | val_raddr_unused),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  lkv_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (rd_addr),
    .rdata (rank_rdata)
  );

  lkv_scan #(.MAX_ENTRIES(MAX_ENTRIES)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (state == S_IDLE),
    .en          (cmp_vld && (state == S_SCAN)),
    .idx         (cmp_idx),
    .entry_valid (valid[cmp_idx]),
    .key_rd      (key_rdata),
    .rank_rd     (rank_rdata),
    .key         (req_q.key),
    .flags       (flags),
    .match_idx   (match_idx),
    .match_rank  (match_rank),
    .free_idx    (free_idx),
    .lru_idx     (lru_idx),
    .lru_key     (lru_key)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= lkv_pkg::CAP_RESET;
      ptr      <= '0;
      cmp_vld  <= 1'b0;
      valid    <= '0;
      count    <= '0;
      op_hit   <= 1'b0;
      op_ins   <= 1'b0;
      op_evict <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          ptr     <= '0;
          cmp_vld <= 1'b0;
          if (req_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN, S_AGE: begin
          if (ptr < PTR_END) begin
            ptr     <= ptr + PTR_W'(1);
            cmp_vld <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
            ptr     <= '0;
            state   <= (state == S_SCAN) ? S_RESOLVE : S_FINISH;
          end
        end
        S_RESOLVE: begin
          op_hit   <= flags.found;
          op_ins   <= res_ins;
          op_evict <= res_evict;
          state    <= (flags.found || res_ins) ? S_AGE : S_OUT;
        end
        S_FINISH: begin
          if (op_ins) begin
            valid[op_tgt] <= 1'b1;
            if (!op_evict) begin
              count <= count + PTR_W'(1);
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == S_SCAN || state == S_AGE) begin
      cmp_idx <= rd_addr;
    end
    if (state == S_RESOLVE) begin
      op_tgt <= res_tgt;
      op_thr <= match_rank;
      rsp    <= '0;
    end
    if (state == S_FINISH) begin
      rsp.hit           <= op_hit;
      rsp.read_value    <= (op_hit && req_q.mode == lkv_pkg::MODE_GET) ? rd_value : '0;
      rsp.evicted       <= op_evict;
      rsp.evicted_key   <= op_evict ? lru_key : '0;
      rsp.evicted_value <= op_evict ? rd_value : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count disagrees with the valid bits");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.evicted))
    else $error("eviction reported on a hit");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.read_value != '0) |-> rsp.hit)
    else $error("read data returned on a miss");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && op_evict) |-> (count == PTR_W'(count) && count != '0))
    else $error("eviction from an empty cache");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for lru_key_value_cache: directed and random gets and puts
// under several capacity settings, with a scoreboard that predicts every response word.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module tb;

  localparam int ENTRIES    = lkv_pkg::DEF_MAX_ENTRIES;
  localparam int POOL_DEPTH = 24;
  localparam int SETTLE     = 2 * ENTRIES + 8;
  localparam int LIMIT      = 600000;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_kind_t;

  // Tracks the cache contents and recency order, and queues the response
  // word that each accepted request word should produce.
  class cache_scoreboard;
    logic [lkv_pkg::CFG_W-1:0]  capacity;
    logic [lkv_pkg::KEY_W-1:0]  keys[ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] values[ENTRIES];
    bit                         valid[ENTRIES];
    int unsigned                rank[ENTRIES];
    int unsigned                count;
    lkv_pkg::rsp_t              expected_rsps[$];
    int                         errors;
    int                         checked;

    function new();
      capacity = lkv_pkg::CAP_RESET;
      count    = 0;
      errors   = 0;
      checked  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] = 1'b0;
        rank[i]  = 0;
      end
    endfunction

    function void set_capacity(logic [lkv_pkg::CFG_W-1:0] v);
      capacity = v;
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    function int unsigned usable_entries();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    // Moves entry e to the front; only entries newer than it age.
    function void make_newest(int e);
      int unsigned r;
      r = rank[e];
      for (int i = 0; i < ENTRIES; i++)
        if (valid[i] && i != e && rank[i] < r) rank[i]++;
      rank[e] = 0;
    endfunction

    function lkv_pkg::rsp_t predict_access(lkv_pkg::req_t word);
      lkv_pkg::rsp_t res;
      int            idx;
      int            slot;
      int unsigned   oldest;
      res    = '0;
      idx    = -1;
      slot   = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (idx < 0 && valid[i] && keys[i] == word.key) idx = i;
      if (idx >= 0) begin
        res.hit = 1'b1;
        if (word.mode == lkv_pkg::MODE_PUT) values[idx] = word.write_value;
        else res.read_value = values[idx];
        make_newest(idx);
      end else if (word.mode == lkv_pkg::MODE_PUT) begin
        if (count >= usable_entries() || count >= ENTRIES) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && (slot < 0 || rank[i] > oldest)) begin
              slot   = i;
              oldest = rank[i];
            end
          if (slot >= 0) begin
            res.evicted       = 1'b1;
            res.evicted_key   = keys[slot];
            res.evicted_value = values[slot];
            valid[slot]       = 1'b0;
            count--;
          end
        end
        if (slot < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (valid[i]) rank[i]++;
          keys[slot]   = word.key;
          values[slot] = word.write_value;
          valid[slot]  = 1'b1;
          rank[slot]   = 0;
          count++;
        end
      end
      return res;
    endfunction

    function void note_request(lkv_pkg::req_t word);
      expected_rsps.push_back(predict_access(word));
    endfunction

    function void report_mismatch(string msg);
      $display("ERROR at %0t: response %0d: %s", $realtime, checked, msg);
      errors++;
    endfunction

    function void check_response(lkv_pkg::rsp_t got);
      lkv_pkg::rsp_t want;
      if (expected_rsps.size() == 0) begin
        report_mismatch("response word with no request outstanding");
        return;
      end
      want = expected_rsps.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value %h, expected %h",
                                  got.read_value, want.read_value));
      if (got.evicted !== want.evicted)
        report_mismatch($sformatf("evicted %b, expected %b", got.evicted, want.evicted));
      if (got.evicted_key !== want.evicted_key)
        report_mismatch($sformatf("evicted_key %h, expected %h",
                                  got.evicted_key, want.evicted_key));
      if (got.evicted_value !== want.evicted_value)
        report_mismatch($sformatf("evicted_value %h, expected %h",
                                  got.evicted_value, want.evicted_value));
      checked++;
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_stall;
  lkv_pkg::req_t             req       = '0;
  logic                      rsp_valid;
  logic                      rsp_stall = 1'b0;
  lkv_pkg::rsp_t             rsp;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [lkv_pkg::CFG_W-1:0] cfg_data  = '0;

  cache_scoreboard           sb;
  int                        burst_left = 0;
  int                        cycle_count = 0;
  int                        stall_left = 0;
  stall_kind_t               stall_kind = STALL_NONE;
  logic [lkv_pkg::KEY_W-1:0] key_pool[POOL_DEPTH];
  int                        pool_size = 1;

  lru_key_value_cache i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // The receiver switches between free running, coin-flip stalls and heavy stalls.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_kind_t'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_kind)
      STALL_NONE:   rsp_stall <= 1'b0;
      STALL_RANDOM: rsp_stall <= 1'($urandom_range(0, 1));
      default:      rsp_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // A gap after a burst lets the next word arrive at any point of the previous one.
  task automatic send_word(input lkv_pkg::req_t word);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 50);
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 20);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= word;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(word);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_op(input logic mode, input logic [lkv_pkg::KEY_W-1:0] key,
                         input logic [lkv_pkg::DATA_W-1:0] value);
    lkv_pkg::req_t word;
    word.mode        = mode;
    word.key         = key;
    word.write_value = value;
    send_word(word);
  endtask

  task automatic wait_idle();
    req_valid  <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [lkv_pkg::CFG_W-1:0] v);
    wait_idle();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Keeps about half of the old keys so that entries left from the last
  // setting still get hit, and sizes the pool around the capacity.
  task automatic refill_pool(input logic [lkv_pkg::CFG_W-1:0] cap);
    int c;
    c = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
    pool_size = c + $urandom_range(0, 4);
    if (pool_size > POOL_DEPTH) pool_size = POOL_DEPTH;
    for (int i = 0; i < POOL_DEPTH; i++)
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 1) == 0) key_pool[i] = $urandom_range(0, 63);
        else key_pool[i] = $urandom;
      end
  endtask

  task automatic send_random_op();
    int                        pick;
    logic [lkv_pkg::KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
    else if (pick < 95) key = $urandom;
    else case ($urandom_range(0, 3))
      0:       key = 32'h8000_0000;
      1:       key = 32'h7FFF_FFFF;
      2:       key = 32'h0000_0000;
      default: key = 32'hFFFF_FFFF;
    endcase
    send_op($urandom_range(0, 1) ? lkv_pkg::MODE_PUT : lkv_pkg::MODE_GET, key, $urandom);
  endtask

  initial begin
    logic [lkv_pkg::CFG_W-1:0] caps[10];
    sb = new();
    for (int i = 0; i < POOL_DEPTH; i++) key_pool[i] = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset capacity: misses on an empty store, extreme keys and values, updates.
    send_op(lkv_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_op(lkv_pkg::MODE_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(lkv_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(lkv_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_op(lkv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_op(lkv_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
    send_op(lkv_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_op(lkv_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(lkv_pkg::MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Capacity zero acts as one, and the store is already above it:
    // a new key evicts the oldest entry but the count stays where it was.
    write_capacity(5'd0);
    send_op(lkv_pkg::MODE_PUT, 32'h0000_0001, 32'h0000_0001);
    send_op(lkv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
    send_op(lkv_pkg::MODE_PUT, 32'h0000_0002, 32'h0000_0002);
    send_op(lkv_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(lkv_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // A capacity above the table size saturates.
    write_capacity(5'd31);
    send_op(lkv_pkg::MODE_PUT, 32'h0000_0010, 32'h0F0F_0F0F);
    send_op(lkv_pkg::MODE_GET, 32'h0000_0002, 32'h0000_0000);

    caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd0, 5'd16, 5'd8};
    caps[7] = 5'($urandom_range(0, 31));
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      refill_pool(caps[p]);
      repeat (110) send_random_op();
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
